// ----- rtl/core/tcat_pkg.sv -----
// Package for the tetrahedron circumsphere alpha test block.
// Widths, pipeline latencies and the result type used by the rtl/core modules.
package tcat_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned NUM_CRD     = 12;
  localparam int unsigned TDATA_IN_W  = NUM_CRD * COORD_W;
  localparam int unsigned TDATA_OUT_W = 8;
  localparam int unsigned ALPHA_W     = 32;

  // Edge vectors, products of edge component pairs, squared lengths.
  localparam int unsigned EDGE_W      = COORD_W + 1;
  localparam int unsigned PROD_W      = 2 * EDGE_W;
  localparam int unsigned LEN2_W      = PROD_W;
  localparam int unsigned MINOR_W     = PROD_W + 1;

  // Squared length is split in two halves for the minor x length product.
  localparam int unsigned LEN2_SPLIT  = LEN2_W / 2;
  localparam int unsigned PART_W      = MINOR_W + (LEN2_W - LEN2_SPLIT) + 1;
  localparam int unsigned NTERM_W     = PART_W + LEN2_SPLIT;
  localparam int unsigned NUM_W       = NTERM_W + 2;
  localparam int unsigned DTERM_W     = MINOR_W + EDGE_W;
  localparam int unsigned DEN_W       = DTERM_W + 2;

  // Limb-split squaring and the alpha multiply.
  localparam int unsigned NUM_LIMB_W  = 24;
  localparam int unsigned DEN_LIMB_W  = 18;
  localparam int unsigned NSQ_W       = 2 * NUM_W;
  localparam int unsigned DSQ_W       = 2 * DEN_W;
  localparam int unsigned RHS_A_W     = DSQ_W + 2;
  localparam int unsigned RHS_W       = RHS_A_W + ALPHA_W;
  localparam int unsigned LHS_W       = NSQ_W + 2;

  localparam int unsigned DET_LAT     = 6;
  localparam int unsigned MUL_LAT     = 3;
  localparam int unsigned CMP_LAT     = 2 * MUL_LAT + 2;
  localparam int unsigned PIPE_LAT    = DET_LAT + CMP_LAT;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } tcat_res_t;

endpackage

// ----- rtl/core/tetra_circumradius_alpha_test_unit.sv -----
// Top level of the tetrahedron circumsphere alpha test.
// Depends on tcat_pkg, tcat_det, tcat_cmp (and tcat_mul below it).
//
// Takes one tetrahedron (four vertices, 16-bit signed coordinates) per clock
// while the output is not stalled and reports whether the squared radius of
// its circumsphere is strictly below alpha_squared, exactly, without division;
// a flat tetrahedron reports degenerate=1 and inside_res=0. One item per cycle
// sustained without output stalls. An item passes six stages of determinant
// arithmetic, then magnitude, a three-stage limb multiplier for the squares,
// a second three-stage multiplier for the alpha product, and the compare.
// All stages advance together, so while a result waits at the output no new
// item is taken. alpha_squared may be written only when no item is in flight.
module tetra_circumradius_alpha_test_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcat_pkg::ALPHA_W-1:0]     cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z, s_x, s_y, s_z (16 bits each)
  input  logic [tcat_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // inside_res (bit 0), zero fill
  output logic [tcat_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  // degenerate
  output logic                             m_axis_tuser
);

  localparam int unsigned Lat = tcat_pkg::PIPE_LAT;

  logic [tcat_pkg::ALPHA_W-1:0]      alpha_q;
  logic [Lat-1:0]                    vld_d;
  logic [Lat-1:0]                    vld_q;
  logic                              adv;
  logic signed [tcat_pkg::NUM_W-1:0] num [3];
  logic signed [tcat_pkg::DEN_W-1:0] den;
  tcat_pkg::tcat_res_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_wdata_i;
    end
  end

  // whole pipe moves when the output slot is free or being taken
  assign adv   = !vld_q[Lat-1] || m_axis_tready;
  assign vld_d = {vld_q[Lat-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  tcat_det u_det (
    .clk_i(clk_i),
    .en_i (adv),
    .crd_i(s_axis_tdata),
    .num_o(num),
    .den_o(den)
  );

  tcat_cmp u_cmp (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (num),
    .den_i  (den),
    .alpha_i(alpha_q),
    .res_o  (res)
  );

  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = tcat_pkg::TDATA_OUT_W'(res.inside_res);
  assign m_axis_tuser  = res.degenerate;

  a_deg_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
    else $error("degenerate item flagged inside");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q) && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item not tracked");

endmodule

// ----- rtl/core/tcat_mul.sv -----
// Pipelined unsigned multiplier built from limb partial products (three stages).
// Depends on tcat_pkg for default widths.
module tcat_mul #(
  parameter int unsigned AW = tcat_pkg::NUM_W,
  parameter int unsigned BW = tcat_pkg::NUM_W,
  parameter int unsigned LW = tcat_pkg::NUM_LIMB_W
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [AW-1:0]  a_i,
  input  logic [BW-1:0]  b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned NA  = (AW + LW - 1) / LW;
  localparam int unsigned NB  = (BW + LW - 1) / LW;
  localparam int unsigned AXW = NA * LW;
  localparam int unsigned BXW = NB * LW;
  localparam int unsigned RW  = BXW + LW;
  localparam int unsigned SW  = AXW + BXW;
  localparam int unsigned PW  = AW + BW;

  logic [AXW-1:0]  a_x;
  logic [BXW-1:0]  b_x;
  logic [2*LW-1:0] pp_q [NA][NB];
  logic [RW-1:0]   row_d [NA];
  logic [RW-1:0]   row_q [NA];
  logic [SW-1:0]   sum_d;
  logic [PW-1:0]   p_q;

  assign a_x = AXW'(a_i);
  assign b_x = BXW'(b_i);

  // row i = limb i of a times all of b; then rows are summed with their weights
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j * LW));
      end
    end
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (SW'(row_q[i]) << (i * LW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_x[i*LW +: LW] * b_x[j*LW +: LW];
        end
        row_q[i] <= row_d[i];
      end
      p_q <= sum_d[PW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/tcat_det.sv -----
// Determinant pipeline: edge vectors, 2x2 minors, numerator and denominator
// determinants in six register stages. Depends on tcat_pkg.
module tcat_det (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [tcat_pkg::TDATA_IN_W-1:0]        crd_i,
  output logic signed [tcat_pkg::NUM_W-1:0]      num_o [3],
  output logic signed [tcat_pkg::DEN_W-1:0]      den_o
);

  // Column pairs of the minors: (y,z) for num x, (x,z) for num y, (x,y) for num z / den.
  localparam int ColU [3] = '{1, 0, 0};
  localparam int ColV [3] = '{2, 2, 1};
  // Row pairs (0,1), (0,2), (1,2) and the remaining row of each.
  localparam int RowA [3] = '{0, 0, 1};
  localparam int RowB [3] = '{1, 2, 2};
  localparam int RowO [3] = '{2, 1, 0};
  localparam int XyPair = 2;
  localparam int ColZ   = 2;

  logic signed [tcat_pkg::COORD_W-1:0] crd [4][3];

  logic signed [tcat_pkg::EDGE_W-1:0]  d_d    [3][3];
  logic signed [tcat_pkg::EDGE_W-1:0]  d_q    [3][3];
  logic        [tcat_pkg::PROD_W-1:0]  sq_d   [3][3];
  logic        [tcat_pkg::PROD_W-1:0]  sq_q   [3][3];
  logic signed [tcat_pkg::PROD_W-1:0]  pa_d   [3][3];
  logic signed [tcat_pkg::PROD_W-1:0]  pa_q   [3][3];
  logic signed [tcat_pkg::PROD_W-1:0]  pb_d   [3][3];
  logic signed [tcat_pkg::PROD_W-1:0]  pb_q   [3][3];
  logic signed [tcat_pkg::EDGE_W-1:0]  dz2_q  [3];
  logic        [tcat_pkg::LEN2_W-1:0]  len2_d [3];
  logic        [tcat_pkg::LEN2_W-1:0]  len2_q [3];
  logic signed [tcat_pkg::MINOR_W-1:0] mnr_d  [3][3];
  logic signed [tcat_pkg::MINOR_W-1:0] mnr_q  [3][3];
  logic signed [tcat_pkg::EDGE_W-1:0]  dz3_q  [3];
  logic signed [tcat_pkg::PART_W-1:0]  plo_d  [3][3];
  logic signed [tcat_pkg::PART_W-1:0]  plo_q  [3][3];
  logic signed [tcat_pkg::PART_W-1:0]  phi_d  [3][3];
  logic signed [tcat_pkg::PART_W-1:0]  phi_q  [3][3];
  logic signed [tcat_pkg::DTERM_W-1:0] dt_d   [3];
  logic signed [tcat_pkg::DTERM_W-1:0] dt_q   [3];
  logic signed [tcat_pkg::NTERM_W-1:0] nt_d   [3][3];
  logic signed [tcat_pkg::NTERM_W-1:0] nt_q   [3][3];
  logic signed [tcat_pkg::DEN_W-1:0]   den5_d;
  logic signed [tcat_pkg::DEN_W-1:0]   den5_q;
  logic signed [tcat_pkg::NUM_W-1:0]   num_d  [3];
  logic signed [tcat_pkg::NUM_W-1:0]   num_q  [3];
  logic signed [tcat_pkg::DEN_W-1:0]   den6_q;

  always_comb begin
    for (int v = 0; v < 4; v++) begin
      for (int i = 0; i < 3; i++) begin
        crd[v][i] = crd_i[(3*v+i)*tcat_pkg::COORD_W +: tcat_pkg::COORD_W];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        d_d[k][i]  = crd[k+1][i] - crd[0][i];
        sq_d[k][i] = tcat_pkg::PROD_W'(d_q[k][i] * d_q[k][i]);
      end
      len2_d[k] = sq_q[k][0] + sq_q[k][1] + sq_q[k][2];
    end
    for (int pc = 0; pc < 3; pc++) begin
      for (int rp = 0; rp < 3; rp++) begin
        pa_d[pc][rp]  = d_q[RowA[rp]][ColU[pc]] * d_q[RowB[rp]][ColV[pc]];
        pb_d[pc][rp]  = d_q[RowB[rp]][ColU[pc]] * d_q[RowA[rp]][ColV[pc]];
        mnr_d[pc][rp] = pa_q[pc][rp] - pb_q[pc][rp];
        // minor times the squared length of the remaining row, in two halves
        plo_d[pc][rp] = mnr_q[pc][rp] *
            $signed({1'b0, len2_q[RowO[rp]][tcat_pkg::LEN2_SPLIT-1:0]});
        phi_d[pc][rp] = mnr_q[pc][rp] *
            $signed({1'b0, len2_q[RowO[rp]][tcat_pkg::LEN2_W-1:tcat_pkg::LEN2_SPLIT]});
        nt_d[pc][rp]  = (tcat_pkg::NTERM_W'(phi_q[pc][rp]) <<< tcat_pkg::LEN2_SPLIT)
                      + tcat_pkg::NTERM_W'(plo_q[pc][rp]);
      end
      // cofactor expansion along the last column: + - +
      num_d[pc] = tcat_pkg::NUM_W'(nt_q[pc][0]) - tcat_pkg::NUM_W'(nt_q[pc][1])
                + tcat_pkg::NUM_W'(nt_q[pc][2]);
    end
    for (int rp = 0; rp < 3; rp++) begin
      dt_d[rp] = mnr_q[XyPair][rp] * dz3_q[RowO[rp]];
    end
    den5_d = tcat_pkg::DEN_W'(dt_q[0]) - tcat_pkg::DEN_W'(dt_q[1])
           + tcat_pkg::DEN_W'(dt_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      sq_q   <= sq_d;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      len2_q <= len2_d;
      mnr_q  <= mnr_d;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      dt_q   <= dt_d;
      nt_q   <= nt_d;
      den5_q <= den5_d;
      num_q  <= num_d;
      den6_q <= den5_q;
      for (int k = 0; k < 3; k++) begin
        dz2_q[k] <= d_q[k][ColZ];
        dz3_q[k] <= dz2_q[k];
      end
    end
  end

  assign num_o = num_q;
  assign den_o = den6_q;

endmodule

// ----- rtl/core/tcat_cmp.sv -----
// Radius test: squares the numerators, forms 4*den^2*alpha and compares.
// Depends on tcat_pkg and tcat_mul.
module tcat_cmp (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [tcat_pkg::NUM_W-1:0]  num_i [3],
  input  logic signed [tcat_pkg::DEN_W-1:0]  den_i,
  input  logic [tcat_pkg::ALPHA_W-1:0]       alpha_i,
  output tcat_pkg::tcat_res_t                res_o
);

  localparam int unsigned DegN = 1 + 2 * tcat_pkg::MUL_LAT;

  logic [tcat_pkg::NUM_W-1:0]   mag_q  [3];
  logic [tcat_pkg::DEN_W-1:0]   dmag_q;
  logic [tcat_pkg::NSQ_W-1:0]   nsq    [3];
  logic [tcat_pkg::DSQ_W-1:0]   dsq;
  logic [tcat_pkg::RHS_W-1:0]   rhs;
  logic [tcat_pkg::LHS_W-1:0]   lhs_d;
  logic [tcat_pkg::LHS_W-1:0]   lhs_q  [tcat_pkg::MUL_LAT];
  logic [DegN-1:0]              deg_q;
  tcat_pkg::tcat_res_t          res_d;
  tcat_pkg::tcat_res_t          res_q;

  for (genvar g = 0; g < 3; g++) begin : g_nsq
    tcat_mul #(
      .AW(tcat_pkg::NUM_W),
      .BW(tcat_pkg::NUM_W),
      .LW(tcat_pkg::NUM_LIMB_W)
    ) u_nsq (
      .clk_i(clk_i),
      .en_i (en_i),
      .a_i  (mag_q[g]),
      .b_i  (mag_q[g]),
      .p_o  (nsq[g])
    );
  end

  tcat_mul #(
    .AW(tcat_pkg::DEN_W),
    .BW(tcat_pkg::DEN_W),
    .LW(tcat_pkg::DEN_LIMB_W)
  ) u_dsq (
    .clk_i(clk_i),
    .en_i (en_i),
    .a_i  (dmag_q),
    .b_i  (dmag_q),
    .p_o  (dsq)
  );

  // (2*den)^2 * alpha
  tcat_mul #(
    .AW(tcat_pkg::RHS_A_W),
    .BW(tcat_pkg::ALPHA_W),
    .LW(tcat_pkg::ALPHA_W)
  ) u_rhs (
    .clk_i(clk_i),
    .en_i (en_i),
    .a_i  ({dsq, 2'b00}),
    .b_i  (alpha_i),
    .p_o  (rhs)
  );

  always_comb begin
    lhs_d = tcat_pkg::LHS_W'(nsq[0]) + tcat_pkg::LHS_W'(nsq[1])
          + tcat_pkg::LHS_W'(nsq[2]);
    res_d.degenerate = deg_q[DegN-1];
    res_d.inside_res = !deg_q[DegN-1] &&
                       (lhs_q[tcat_pkg::MUL_LAT-1] < tcat_pkg::LHS_W'(rhs));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= num_i[i][tcat_pkg::NUM_W-1] ? $unsigned(-num_i[i])
                                                : $unsigned(num_i[i]);
      end
      dmag_q <= den_i[tcat_pkg::DEN_W-1] ? $unsigned(-den_i) : $unsigned(den_i);
      deg_q  <= {deg_q[DegN-2:0], (den_i == '0)};
      // numerator sum waits here for the alpha product
      lhs_q[0] <= lhs_d;
      for (int i = 1; i < tcat_pkg::MUL_LAT; i++) begin
        lhs_q[i] <= lhs_q[i-1];
      end
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
